// ----- rtl/bsab_pkg.sv -----
// Shared types, constants and per-channel arithmetic for the bilinear sampler and blender.
// No dependencies; every other file in rtl refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bsab_pkg;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int PIX_W    = CH_W * NUM_CH;
  localparam int ALPHA_CH = 3;

  // Full-scale channel value and rounding bias of the blend
  localparam logic [CH_W-1:0] CH_MAX      = 8'd255;
  localparam logic [CH_W-1:0] BLEND_ROUND = 8'd127;

  // Width of the blend numerator s*a + d*(255-a) + 127 (peaks at 65152)
  localparam int SUM_W = 2 * CH_W + 1;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Pipeline advance control shared by the lanes and the blend stage
  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  // One interpolation step: a + floor(f * (b - a) / 256)
  function automatic chan_t lerp8(input chan_t a, input chan_t b, input chan_t f);
    logic signed [CH_W:0]     diff;
    logic signed [2*CH_W+1:0] prod;
    logic signed [CH_W+1:0]   step;
    logic signed [CH_W+1:0]   res;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = $signed({1'b0, f}) * diff;
    // arithmetic shift floors toward minus infinity
    step = prod[2*CH_W+1:CH_W];
    res  = $signed({2'b00, a}) + step;
    return res[CH_W-1:0];
  endfunction

  // Truncating divide by 255 for numerators below 65280
  function automatic chan_t div255(input sum_t x);
    logic [SUM_W:0] t;
    t = {1'b0, x} + {{(CH_W+1){1'b0}}, x[SUM_W-1:CH_W]} + {{SUM_W{1'b0}}, 1'b1};
    return t[CH_W+CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsab_lane.sv -----
// One colour channel lane: horizontal then vertical interpolation over two register stages.
// Depends on bsab_pkg for the channel type, control struct and lerp8.
`timescale 1ns / 1ps
`default_nettype none

module bsab_lane (
  input  wire                  clk,
  input  bsab_pkg::pipe_ctl_t  ctl,
  input  bsab_pkg::chan_t      top_left,
  input  bsab_pkg::chan_t      top_right,
  input  bsab_pkg::chan_t      bottom_left,
  input  bsab_pkg::chan_t      bottom_right,
  input  bsab_pkg::chan_t      frac_x,
  input  bsab_pkg::chan_t      frac_y,
  output bsab_pkg::chan_t      src
);

  bsab_pkg::chan_t top_row;
  bsab_pkg::chan_t bottom_row;
  bsab_pkg::chan_t frac_y_d;

  // Interpolate along the top and bottom rows
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      top_row    <= bsab_pkg::lerp8(top_left, top_right, frac_x);
      bottom_row <= bsab_pkg::lerp8(bottom_left, bottom_right, frac_x);
      frac_y_d   <= frac_y;
    end
  end

  // Interpolate between the two rows
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      src <= bsab_pkg::lerp8(top_row, bottom_row, frac_y_d);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsab_blend.sv -----
// Merge stage: blends the four interpolated channels over the destination pixel.
// Depends on bsab_pkg; the alpha lane's result weights every channel.
`timescale 1ns / 1ps
`default_nettype none

module bsab_blend (
  input  wire                  clk,
  input  bsab_pkg::pipe_ctl_t  ctl,
  input  bsab_pkg::pixel_t     src_pixel,
  input  bsab_pkg::pixel_t     dst_pixel,
  output bsab_pkg::pixel_t     out_pixel
);

  bsab_pkg::sum_t  num [bsab_pkg::NUM_CH];
  bsab_pkg::chan_t alpha;
  bsab_pkg::chan_t alpha_inv;

  assign alpha     = src_pixel[bsab_pkg::ALPHA_CH*bsab_pkg::CH_W +: bsab_pkg::CH_W];
  assign alpha_inv = bsab_pkg::CH_MAX - alpha;

  // Form the weighted sums; alpha blends with itself as the source
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int c = 0; c < bsab_pkg::NUM_CH; c++) begin
        num[c] <= bsab_pkg::SUM_W'(src_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] * alpha)
                + bsab_pkg::SUM_W'(dst_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] * alpha_inv)
                + bsab_pkg::SUM_W'(bsab_pkg::BLEND_ROUND);
      end
    end
  end

  // Divide by 255 and pack the result
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int c = 0; c < bsab_pkg::NUM_CH; c++) begin
        out_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] <= bsab_pkg::div255(num[c]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bilinear_sample_alpha_blend.sv -----
// Bilinear sampler with alpha blend over the destination pixel.
// An accepted input transaction reaches the output through four register stages.
// Throughput: one pixel per clock; the four stages advance together, held only while
// a result sits on the output under stall. Two stages interpolate, two blend and divide.
// Reset (rst, synchronous) clears the stage valid bits only; no data is cleared.
// Depends on bsab_pkg, bsab_lane and bsab_blend.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_sample_alpha_blend (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [31:0] top_left_pixel,
  input  wire [31:0] top_right_pixel,
  input  wire [31:0] bottom_left_pixel,
  input  wire [31:0] bottom_right_pixel,
  input  wire [7:0]  frac_x,
  input  wire [7:0]  frac_y,
  input  wire [31:0] dest_pixel,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [31:0] blended_pixel
);

  bsab_pkg::pipe_ctl_t ctl;
  logic                advance;
  logic                v1;
  logic                v2;
  logic                v3;
  bsab_pkg::pixel_t    dest_d1;
  bsab_pkg::pixel_t    dest_d2;
  bsab_pkg::pixel_t    src_pixel;

  // Move every stage unless the output holds an untaken result
  assign advance  = !(out_valid && out_stall);
  assign ctl.en   = advance;
  assign in_stall = !advance;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Carry the destination alongside the interpolation stages
  always_ff @(posedge clk) begin
    if (advance) begin
      dest_d1 <= dest_pixel;
      dest_d2 <= dest_d1;
    end
  end

  // One interpolation lane per channel
  for (genvar c = 0; c < bsab_pkg::NUM_CH; c++) begin : g_lane
    bsab_lane u_lane (
      .clk          (clk),
      .ctl          (ctl),
      .top_left     (top_left_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W]),
      .top_right    (top_right_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W]),
      .bottom_left  (bottom_left_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W]),
      .bottom_right (bottom_right_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W]),
      .frac_x       (frac_x),
      .frac_y       (frac_y),
      .src          (src_pixel[c*bsab_pkg::CH_W +: bsab_pkg::CH_W])
    );
  end

  // Combine the lanes and blend over the destination
  bsab_blend u_blend (
    .clk       (clk),
    .ctl       (ctl),
    .src_pixel (src_pixel),
    .dst_pixel (dest_d2),
    .out_pixel (blended_pixel)
  );

  // Input is only held back by a stalled output result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output result");

  // An accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted transaction lost at first stage");

  // The output never turns valid while the last stage is empty and the pipeline advances
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!v3 && advance) |=> !out_valid)
    else $error("output valid with empty last stage");

  // A held result keeps its stage behind it frozen
  a_hold_v3: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (v3 == $past(v3)))
    else $error("stage advanced under output stall");

endmodule

`default_nettype wire

// ----- tb/bilinear_sample_alpha_blend_test.sv -----
// Self-checking testbench for bilinear_sample_alpha_blend: bilinear interpolation and alpha blend.
// Predicts each blended pixel from the accepted input transaction and checks results in order.
// Depends on bsab_pkg and the RTL of bilinear_sample_alpha_blend.
`timescale 1ns / 1ps

module bilinear_sample_alpha_blend_test;

  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 200_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  bsab_pkg::pixel_t top_left_pixel = '0;
  bsab_pkg::pixel_t top_right_pixel = '0;
  bsab_pkg::pixel_t bottom_left_pixel = '0;
  bsab_pkg::pixel_t bottom_right_pixel = '0;
  bsab_pkg::chan_t  frac_x = '0;
  bsab_pkg::chan_t  frac_y = '0;
  bsab_pkg::pixel_t dest_pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  bsab_pkg::pixel_t blended_pixel;

  bsab_pkg::pixel_t expected_pixels[$];
  bsab_pkg::pixel_t wanted_pixel;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               stall_left = 0;
  bit               feed_gaps_on = 1'b0;
  bit               out_stall_on = 1'b0;

  bilinear_sample_alpha_blend dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .top_left_pixel     (top_left_pixel),
    .top_right_pixel    (top_right_pixel),
    .bottom_left_pixel  (bottom_left_pixel),
    .bottom_right_pixel (bottom_right_pixel),
    .frac_x             (frac_x),
    .frac_y             (frac_y),
    .dest_pixel         (dest_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .blended_pixel      (blended_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One interpolation step; the arithmetic shift floors negative products
  function automatic bsab_pkg::chan_t interp_step(bsab_pkg::chan_t lo, bsab_pkg::chan_t hi,
                                                  bsab_pkg::chan_t w);
    int delta;
    delta = int'(w) * (int'(hi) - int'(lo));
    return bsab_pkg::chan_t'(int'(lo) + (delta >>> 8));
  endfunction

  // Weighted blend of one channel with rounding, truncating divide by full scale
  function automatic bsab_pkg::chan_t blend_channel(bsab_pkg::chan_t src, bsab_pkg::chan_t dst,
                                                    bsab_pkg::chan_t wgt);
    int num;
    num = int'(src) * int'(wgt) + int'(dst) * (int'(bsab_pkg::CH_MAX) - int'(wgt))
        + int'(bsab_pkg::BLEND_ROUND);
    return bsab_pkg::chan_t'(num / int'(bsab_pkg::CH_MAX));
  endfunction

  // Interpolate all four channels, then blend over the destination with the new alpha.
  // The alpha channel uses the same formula, its source being the alpha itself.
  function automatic bsab_pkg::pixel_t predict_blend(
      bsab_pkg::pixel_t tl, bsab_pkg::pixel_t tr, bsab_pkg::pixel_t bl, bsab_pkg::pixel_t br,
      bsab_pkg::chan_t fx, bsab_pkg::chan_t fy, bsab_pkg::pixel_t dst);
    bsab_pkg::chan_t  mixed [bsab_pkg::NUM_CH];
    bsab_pkg::chan_t  top;
    bsab_pkg::chan_t  bot;
    bsab_pkg::pixel_t res;
    res = '0;
    for (int c = 0; c < bsab_pkg::NUM_CH; c++) begin
      top = interp_step(tl[c*bsab_pkg::CH_W +: bsab_pkg::CH_W],
                        tr[c*bsab_pkg::CH_W +: bsab_pkg::CH_W], fx);
      bot = interp_step(bl[c*bsab_pkg::CH_W +: bsab_pkg::CH_W],
                        br[c*bsab_pkg::CH_W +: bsab_pkg::CH_W], fx);
      mixed[c] = interp_step(top, bot, fy);
    end
    for (int c = 0; c < bsab_pkg::NUM_CH; c++)
      res[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] =
        blend_channel(mixed[c], dst[c*bsab_pkg::CH_W +: bsab_pkg::CH_W],
                      mixed[bsab_pkg::ALPHA_CH]);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Record the expected pixel for every accepted input transaction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_pixels.push_back(predict_blend(top_left_pixel, top_right_pixel,
                                              bottom_left_pixel, bottom_right_pixel,
                                              frac_x, frac_y, dest_pixel));
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h", blended_pixel));
      end else begin
        wanted_pixel = expected_pixels.pop_front();
        if (blended_pixel !== wanted_pixel)
          report_mismatch($sformatf("blended_pixel %08h, expected %08h",
                                    blended_pixel, wanted_pixel));
      end
    end
  end

  // Apply random stall bursts on the result side while out_stall_on is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_stall_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one transaction, hold it until accepted, then maybe leave a gap
  task automatic send_pixel(bsab_pkg::pixel_t tl, bsab_pkg::pixel_t tr, bsab_pkg::pixel_t bl,
                            bsab_pkg::pixel_t br, bsab_pkg::chan_t fx, bsab_pkg::chan_t fy,
                            bsab_pkg::pixel_t dst);
    int gap;
    top_left_pixel     <= tl;
    top_right_pixel    <= tr;
    bottom_left_pixel  <= bl;
    bottom_right_pixel <= br;
    frac_x             <= fx;
    frac_y             <= fy;
    dest_pixel         <= dst;
    in_valid           <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (feed_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Channels biased towards the extremes, where floors and blends are hardest
  function automatic bsab_pkg::pixel_t edgy_pixel();
    bsab_pkg::pixel_t p;
    for (int c = 0; c < bsab_pkg::NUM_CH; c++) begin
      case ($urandom_range(0, 4))
        0:       p[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] = 8'h00;
        1:       p[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] = 8'hFF;
        2:       p[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] =
                   bsab_pkg::chan_t'($urandom_range(0, 3));
        3:       p[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] =
                   bsab_pkg::chan_t'($urandom_range(252, 255));
        default: p[c*bsab_pkg::CH_W +: bsab_pkg::CH_W] = bsab_pkg::chan_t'($urandom);
      endcase
    end
    return p;
  endfunction

  function automatic bsab_pkg::chan_t pick_frac();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return bsab_pkg::chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Lower valid and hold off until every expected pixel has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // zero and full-scale everything
    send_pixel('0, '0, '0, '0, 8'h00, 8'h00, '0);
    send_pixel('1, '1, '1, '1, 8'hFF, 8'hFF, '1);
    // falling edge: floor must round the small negative step downwards
    send_pixel(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 8'h01, 8'h00, '0);
    send_pixel(32'h01010101, 32'h00000000, 32'h01010101, 32'h00000000, 8'hFF, 8'hFF, '0);
    // rising edge by one: step of 255/256 floors to nothing
    send_pixel(32'h00000000, 32'h01010101, 32'h00000000, 32'h01010101, 8'hFF, 8'h00, '1);
    send_pixel(32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 8'hFF, 8'hFF, '0);
    send_pixel(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 8'h80, 8'h80,
               32'h12345678);
    // zero fraction picks the first corner exactly
    send_pixel(32'hC3A55A3C, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h11111111, 8'h00, 8'h00,
               32'h00000000);
    send_pixel(32'h10203040, 32'hE0D0C0B0, 32'h99999999, 32'h66666666, 8'hFF, 8'h00,
               32'h80808080);
    // transparent source keeps the destination colours
    send_pixel(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 8'h40, 8'hC0,
               32'h80402010);
    // opaque source replaces the destination
    send_pixel(32'hFF808080, 32'hFF808080, 32'hFF808080, 32'hFF808080, 8'h7F, 8'h81, '1);
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h33, 8'hCC, '0);
    send_pixel(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA, 8'hAA, 8'h55,
               32'h55AA55AA);
    send_pixel(32'h7F000000, 32'h7FFFFFFF, 32'h80000000, 32'h80FFFFFF, 8'h80, 8'h01,
               32'hFF00FF00);
    send_pixel(32'h01FE01FE, 32'hFE01FE01, 32'hFE01FE01, 32'h01FE01FE, 8'hFE, 8'hFE,
               32'h01010101);
    wait_for_drain();
  endtask

  // Uniform random transactions, with stretches of idling and none chosen at random
  task automatic test_random_uniform(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        feed_gaps_on = $urandom_range(0, 2) != 0;
        out_stall_on = $urandom_range(0, 2) != 0;
      end
      send_pixel($urandom, $urandom, $urandom, $urandom, bsab_pkg::chan_t'($urandom),
                 bsab_pkg::chan_t'($urandom), $urandom);
    end
  endtask

  // Corner-heavy channels and fractions, idling on both sides
  task automatic test_random_extremes(int count);
    feed_gaps_on = 1'b1;
    out_stall_on = 1'b1;
    for (int i = 0; i < count; i++)
      send_pixel(edgy_pixel(), edgy_pixel(), edgy_pixel(), edgy_pixel(), pick_frac(),
                 pick_frac(), edgy_pixel());
  endtask

  // Full rate, no idling on either side
  task automatic test_back_to_back(int count);
    feed_gaps_on = 1'b0;
    out_stall_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_pixel($urandom, edgy_pixel(), $urandom, edgy_pixel(), pick_frac(),
                 bsab_pkg::chan_t'($urandom), $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_uniform(300);
    wait_for_drain();
    test_random_extremes(150);
    test_random_uniform(150);
    wait_for_drain();
    test_random_extremes(100);
    test_back_to_back(150);

    wait_for_drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
